// ===== rtl/rttu_pkg.sv =====
// ----------------------------------------------------------------------------
// rttu_pkg
// Shared constants and types of the streaming text-to-unsigned converter.
// ----------------------------------------------------------------------------
package rttu_pkg;

   localparam int unsigned CHAR_W    = 8;
   localparam int unsigned RADIX_W   = 5;
   localparam int unsigned VALUE_W   = 64;
   localparam int unsigned OFFSET_W  = 16;
   localparam int unsigned DIGIT_W   = 4;

   localparam longint unsigned MAX_LENGTH = 64'd65535;
   localparam longint unsigned OFFSET_MAX = (64'd1 << OFFSET_W) - 64'd1;
   localparam logic [OFFSET_W-1:0] COUNT_CAP =
      OFFSET_W'((MAX_LENGTH > OFFSET_MAX) ? OFFSET_MAX : MAX_LENGTH);

   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_HEX   = RADIX_W'(16);

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LC_F  = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UC_F  = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_LC_X  = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_UC_X  = 8'h58;

   // Classification of one character against the current base
   typedef struct packed {
      logic                 radix_ok;
      logic                 radix_hex;
      logic                 is_space;
      logic                 is_zero;
      logic                 is_x;
      logic                 digit_ok;
      logic [DIGIT_W-1:0]   digit;
   } char_class_type;

endpackage

// ===== rtl/rttu_if.sv =====
// ----------------------------------------------------------------------------
// rttu_if
// Valid/ready channels: character words in, conversion result words out.
// ----------------------------------------------------------------------------
interface rttu_req_if;
   logic                              valid;
   logic                              ready;
   logic [rttu_pkg::CHAR_W-1:0]       char_code;
   logic                              first_of_string;

   modport source (output valid, output char_code, output first_of_string, input ready);
   modport sink   (input valid, input char_code, input first_of_string, output ready);
endinterface

interface rttu_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rttu_pkg::VALUE_W-1:0]      value;
   logic [rttu_pkg::OFFSET_W-1:0]     end_offset;
   logic                              no_digits;

   modport source (output valid, output value, output end_offset, output no_digits,
                   input ready);
   modport sink   (input valid, input value, input end_offset, input no_digits,
                   output ready);
endinterface

// ===== rtl/rttu_char_class.sv =====
// ----------------------------------------------------------------------------
// rttu_char_class
// Classifies one character: whitespace, zero, x/X, digit value below base.
// ----------------------------------------------------------------------------
module rttu_char_class (
   input  logic [rttu_pkg::CHAR_W-1:0]  char_code,
   input  logic [rttu_pkg::RADIX_W-1:0] radix,
   output rttu_pkg::char_class_type     cls
);

   logic                          is_dec;
   logic                          is_lc;
   logic                          is_uc;
   logic [rttu_pkg::CHAR_W-1:0]   raw_digit;

   always_comb begin
      is_dec = (char_code >= rttu_pkg::CHAR_0)    && (char_code <= rttu_pkg::CHAR_9);
      is_lc  = (char_code >= rttu_pkg::CHAR_LC_A) && (char_code <= rttu_pkg::CHAR_LC_F);
      is_uc  = (char_code >= rttu_pkg::CHAR_UC_A) && (char_code <= rttu_pkg::CHAR_UC_F);

      if (is_dec) begin
         raw_digit = char_code - rttu_pkg::CHAR_0;
      end else if (is_lc) begin
         raw_digit = char_code - rttu_pkg::CHAR_LC_A + 8'd10;
      end else begin
         raw_digit = char_code - rttu_pkg::CHAR_UC_A + 8'd10;
      end

      cls.radix_ok  = (radix >= rttu_pkg::RADIX_MIN) && (radix <= rttu_pkg::RADIX_HEX);
      cls.radix_hex = (radix == rttu_pkg::RADIX_HEX);
      cls.is_space  = (char_code == rttu_pkg::CHAR_SPACE) ||
                      ((char_code >= rttu_pkg::CHAR_TAB) && (char_code <= rttu_pkg::CHAR_CR));
      cls.is_zero   = (char_code == rttu_pkg::CHAR_0);
      cls.is_x      = (char_code == rttu_pkg::CHAR_LC_X) || (char_code == rttu_pkg::CHAR_UC_X);
      cls.digit     = raw_digit[rttu_pkg::DIGIT_W-1:0];
      cls.digit_ok  = (is_dec || is_lc || is_uc) &&
                      ({1'b0, raw_digit[rttu_pkg::DIGIT_W-1:0]} < radix);
   end

endmodule

// ===== rtl/rttu_parse.sv =====
// ----------------------------------------------------------------------------
// rttu_parse
// Parse state, digit accumulation and the result register.
// ----------------------------------------------------------------------------
module rttu_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     first_of_string,
   input  logic [rttu_pkg::RADIX_W-1:0] radix,
   input  rttu_pkg::char_class_type cls,
   output logic                     stage_free,
   rttu_rsp_if.source               rsp_chan
);

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_ZERO,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [rttu_pkg::VALUE_W-1:0]     acc_ff, acc_in;
   logic [rttu_pkg::OFFSET_W-1:0]    count_ff, count_in;
   logic                             seen_ff, seen_in;
   logic                             lzero_ff, lzero_in;
   logic                             rsp_valid_ff;
   logic [rttu_pkg::VALUE_W-1:0]     rsp_value_ff;
   logic [rttu_pkg::OFFSET_W-1:0]    rsp_offset_ff;
   logic                             rsp_nodig_ff;

   phase_type                        ph;
   logic [rttu_pkg::VALUE_W-1:0]     acc;
   logic [rttu_pkg::OFFSET_W-1:0]    count;
   logic [rttu_pkg::OFFSET_W-1:0]    count_bump;
   logic                             seen;
   logic                             lzero;
   logic                             to_digits;
   logic [rttu_pkg::VALUE_W-1:0]     product;
   logic                             emit;
   logic [rttu_pkg::VALUE_W-1:0]     emit_value;
   logic [rttu_pkg::OFFSET_W-1:0]    emit_offset;
   logic                             emit_nodig;

   assign stage_free = !rsp_valid_ff || rsp_chan.ready;

   // acc * radix as five shifted partial terms
   always_comb begin
      product = '0;
      for (int i = 0; i < int'(rttu_pkg::RADIX_W); i++) begin
         if (radix[i]) begin
            product = product + (acc << i);
         end
      end
   end

   always_comb begin
      ph    = first_of_string ? PH_SPACE : phase_ff;
      acc   = first_of_string ? '0 : acc_ff;
      count = first_of_string ? '0 : count_ff;
      seen  = first_of_string ? 1'b0 : seen_ff;
      lzero = first_of_string ? 1'b0 : lzero_ff;

      count_bump  = (count < rttu_pkg::COUNT_CAP) ? count + 1'b1 : count;
      phase_in    = ph;
      acc_in      = acc;
      count_in    = count;
      seen_in     = seen;
      lzero_in    = lzero;
      to_digits   = 1'b0;
      emit        = 1'b0;
      emit_value  = '0;
      emit_offset = '0;
      emit_nodig  = 1'b1;

      if (ph == PH_DONE) begin
         // words are dropped until the next string starts
      end else if (!cls.radix_ok) begin
         emit     = 1'b1;
         phase_in = PH_DONE;
      end else begin
         case (ph)
            PH_SPACE: begin
               if (cls.is_space) begin
                  count_in = count_bump;
               end else if (cls.radix_hex && cls.is_zero) begin
                  phase_in = PH_ZERO;
                  count_in = count_bump;
               end else begin
                  to_digits = 1'b1;
               end
            end
            PH_ZERO: begin
               if (cls.is_x) begin
                  lzero_in = 1'b1;
                  phase_in = PH_DIGITS;
                  count_in = count_bump;
               end else begin
                  // pending zero was an ordinary digit
                  seen      = 1'b1;
                  acc       = '0;
                  to_digits = 1'b1;
               end
            end
            PH_DIGITS: begin
               to_digits = 1'b1;
            end
            default: begin
               to_digits = 1'b0;
            end
         endcase

         if (to_digits) begin
            if (cls.digit_ok) begin
               phase_in = PH_DIGITS;
               acc_in   = product + rttu_pkg::VALUE_W'(cls.digit);
               seen_in  = 1'b1;
               count_in = count_bump;
            end else begin
               emit     = 1'b1;
               phase_in = PH_DONE;
               seen_in  = seen;
               acc_in   = acc;
               if (seen) begin
                  emit_value  = acc;
                  emit_offset = count;
                  emit_nodig  = 1'b0;
               end else if (lzero) begin
                  emit_offset = (count != '0) ? count - 1'b1 : '0;
                  emit_nodig  = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SPACE;
         acc_ff        <= '0;
         count_ff      <= '0;
         seen_ff       <= 1'b0;
         lzero_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_value_ff  <= '0;
         rsp_offset_ff <= '0;
         rsp_nodig_ff  <= 1'b0;
      end else begin
         if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (step) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            count_ff <= count_in;
            seen_ff  <= seen_in;
            lzero_ff <= lzero_in;
            if (emit) begin
               rsp_valid_ff  <= 1'b1;
               rsp_value_ff  <= emit_value;
               rsp_offset_ff <= emit_offset;
               rsp_nodig_ff  <= emit_nodig;
            end
         end
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.value      = rsp_value_ff;
   assign rsp_chan.end_offset = rsp_offset_ff;
   assign rsp_chan.no_digits  = rsp_nodig_ff;

endmodule

// ===== rtl/radix_text_to_unsigned.sv =====
// ----------------------------------------------------------------------------
// radix_text_to_unsigned
// Streaming strtoull-style converter, base 2 to 16, one character per word.
// ----------------------------------------------------------------------------
// Takes one character word per clock cycle, back to back, for as long as the
// result side keeps up. A character passes an input register, then the
// classify, multiply-by-base and add into the parse state; the result word
// is registered when the character that ends the string steps through.
// Throughput is set by the single accumulate step (64-bit value times a 5-bit
// base), which sees every character once. A held result stalls the input
// only when the next character is already waiting in the input register.
// The base register is written through csr_write_enable / csr_write_data and
// resets to 10; write it only while no string is in flight.
// ----------------------------------------------------------------------------
module radix_text_to_unsigned (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [rttu_pkg::RADIX_W-1:0] csr_write_data,
   rttu_req_if.sink                     req_chan,
   rttu_rsp_if.source                   rsp_chan
);

   logic [rttu_pkg::RADIX_W-1:0]  radix_ff;
   logic                          in_valid_ff;
   logic [rttu_pkg::CHAR_W-1:0]   in_char_ff;
   logic                          in_first_ff;
   logic                          stage_free;
   logic                          step;
   rttu_pkg::char_class_type      cls;

   assign step           = in_valid_ff && stage_free;
   assign req_chan.ready = !in_valid_ff || stage_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= rttu_pkg::RADIX_RESET;
         in_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            radix_ff <= csr_write_data;
         end
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_char_ff  <= req_chan.char_code;
         in_first_ff <= req_chan.first_of_string;
      end
   end

   rttu_char_class u_class (
      .char_code (in_char_ff),
      .radix     (radix_ff),
      .cls       (cls)
   );

   rttu_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .first_of_string (in_first_ff),
      .radix           (radix_ff),
      .cls             (cls),
      .stage_free      (stage_free),
      .rsp_chan        (rsp_chan)
   );

endmodule
